### rtl/md5_message_digest_unit_defines.svh
// Assertion macros used by the MD5 digest core RTL.
`ifndef MD5_MESSAGE_DIGEST_UNIT_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MD5_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MD5_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/md5_pkg.sv
// Types, constants and round tables for the MD5 digest unit.
package md5_pkg;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } out_t;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  typedef enum logic [1:0] {
    OP_START,
    OP_DATA,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
  } q_entry_t;

  // What the front hands to the back: a queued entry and its valid flag.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_FIN,
    ST_PAD,
    ST_EMIT
  } st_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS  = 6'd56;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    k = '0;
    case (i)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_shift(input logic [5:0] i);
    logic [4:0] s;
    s = '0;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = '0;
    endcase
    return s;
  endfunction

  // Message word index used by round i.
  function automatic logic [3:0] md5_widx(input logic [5:0] i);
    logic [3:0] g;
    logic [3:0] r;
    r = i[3:0];
    g = '0;
    case (i[5:4])
      2'd0: g = r;
      2'd1: g = 4'((r << 2) + r + 4'd1);
      2'd2: g = 4'((r << 1) + r + 4'd5);
      2'd3: g = 4'((r << 3) - r);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

### rtl/md5_front.sv
// Input front end: accepts transactions, classifies commands and queues them.
module md5_front #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  md5_pkg::in_t     in_data,
  output md5_pkg::q_head_t q_head,
  input  logic             q_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  md5_pkg::q_entry_t q_mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          keep;
  logic          push;
  logic          pop;
  md5_pkg::q_entry_t entry;

  always_comb begin
    keep  = 1'b1;
    entry = '{op: md5_pkg::OP_DATA, data_byte: in_data.data_byte};
    unique case (in_data.cmd)
      md5_pkg::CMD_START:  entry.op = md5_pkg::OP_START;
      md5_pkg::CMD_DATA:   entry.op = md5_pkg::OP_DATA;
      md5_pkg::CMD_FINISH: entry.op = md5_pkg::OP_FINISH;
      default:             keep = 1'b0;
    endcase
  end

  assign in_ready     = (cnt_r != FULL_CNT);
  assign push         = in_valid && in_ready && keep;
  assign pop          = q_pop && (cnt_r != '0);
  assign q_head.valid = (cnt_r != '0);
  assign q_head.entry = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

endmodule

### rtl/md5_core.sv
// Back end: block buffer, round engine, padding sequencer and digest output.
`include "md5_message_digest_unit_defines.svh"
module md5_core (
  input  logic             clk,
  input  logic             rst_n,
  input  md5_pkg::q_head_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output md5_pkg::out_t    out_data
);

  md5_pkg::st_t state_r, state_nxt;
  md5_pkg::st_t ret_r, ret_nxt;
  logic [31:0]  chain_r [4];
  logic [31:0]  chain_nxt [4];
  logic [31:0]  a_r, b_r, c_r, d_r;
  logic [31:0]  a_nxt, b_nxt, c_nxt, d_nxt;
  logic [5:0]   round_r, round_nxt;
  logic [63:0]  count_r, count_nxt;
  logic [5:0]   pad_pos_r, pad_pos_nxt;
  logic         pad_first_r, pad_first_nxt;
  logic         len_blk_r, len_blk_nxt;
  logic [3:0]   emit_idx_r, emit_idx_nxt;
  logic         out_valid_r, out_valid_nxt;
  md5_pkg::out_t out_data_r, out_data_nxt;
  logic         emit_load;

  logic [3:0][7:0] buf_r [16];
  logic         wr_en;
  logic [5:0]   wr_pos;
  logic [7:0]   wr_byte;

  logic [31:0]  f;
  logic [31:0]  sum;
  logic [63:0]  rot_wide;
  logic [31:0]  b_new;
  logic [5:0]   pos;

  assign pos = count_r[8:3];

  // One MD5 round on the working registers.
  always_comb begin
    f = '0;
    case (round_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      2'd3: f = c_r ^ (b_r | ~d_r);
      default: f = '0;
    endcase
    sum      = a_r + f + md5_pkg::md5_k(round_r) + buf_r[md5_pkg::md5_widx(round_r)];
    rot_wide = {sum, sum} << md5_pkg::md5_shift(round_r);
    b_new    = b_r + rot_wide[63:32];
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    chain_nxt     = chain_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    round_nxt     = round_r;
    count_nxt     = count_r;
    pad_pos_nxt   = pad_pos_r;
    pad_first_nxt = pad_first_r;
    len_blk_nxt   = len_blk_r;
    emit_idx_nxt  = emit_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_pos        = pos;
    wr_byte       = q_head.entry.data_byte;
    emit_load     = !out_valid_r || out_ready;

    unique case (state_r)
      md5_pkg::ST_IDLE: begin
        if (q_head.valid) begin
          q_pop = 1'b1;
          unique case (q_head.entry.op)
            md5_pkg::OP_START: begin
              chain_nxt = '{md5_pkg::IV0, md5_pkg::IV1, md5_pkg::IV2, md5_pkg::IV3};
              count_nxt = '0;
            end
            md5_pkg::OP_DATA: begin
              wr_en     = 1'b1;
              count_nxt = count_r + 64'd8;
              if (pos == 6'd63) begin
                a_nxt     = chain_r[0];
                b_nxt     = chain_r[1];
                c_nxt     = chain_r[2];
                d_nxt     = chain_r[3];
                round_nxt = '0;
                ret_nxt   = md5_pkg::ST_IDLE;
                state_nxt = md5_pkg::ST_COMP;
              end
            end
            md5_pkg::OP_FINISH: begin
              pad_pos_nxt   = pos;
              pad_first_nxt = 1'b1;
              len_blk_nxt   = (pos < md5_pkg::LEN_POS);
              state_nxt     = md5_pkg::ST_PAD;
            end
            default: ;
          endcase
        end
      end
      md5_pkg::ST_COMP: begin
        a_nxt     = d_r;
        d_nxt     = c_r;
        c_nxt     = b_r;
        b_nxt     = b_new;
        round_nxt = 6'(round_r + 1'b1);
        if (round_r == 6'd63) begin
          state_nxt = md5_pkg::ST_FIN;
        end
      end
      md5_pkg::ST_FIN: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        state_nxt    = ret_r;
      end
      md5_pkg::ST_PAD: begin
        wr_en  = 1'b1;
        wr_pos = pad_pos_r;
        if (pad_first_r) begin
          wr_byte = md5_pkg::PAD_BYTE;
        end else if (len_blk_r && (pad_pos_r >= md5_pkg::LEN_POS)) begin
          wr_byte = count_r[{pad_pos_r[2:0], 3'b000} +: 8];
        end else begin
          wr_byte = '0;
        end
        pad_first_nxt = 1'b0;
        pad_pos_nxt   = 6'(pad_pos_r + 1'b1);
        if (pad_pos_r == 6'd63) begin
          a_nxt     = chain_r[0];
          b_nxt     = chain_r[1];
          c_nxt     = chain_r[2];
          d_nxt     = chain_r[3];
          round_nxt = '0;
          state_nxt = md5_pkg::ST_COMP;
          if (len_blk_r) begin
            ret_nxt = md5_pkg::ST_EMIT;
          end else begin
            ret_nxt     = md5_pkg::ST_PAD;
            len_blk_nxt = 1'b1;
          end
        end
      end
      md5_pkg::ST_EMIT: begin
        if (emit_load) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.digest_byte =
            chain_r[emit_idx_r[3:2]][{emit_idx_r[1:0], 3'b000} +: 8];
          out_data_nxt.digest_last = (emit_idx_r == 4'd15);
          emit_idx_nxt             = 4'(emit_idx_r + 1'b1);
          if (emit_idx_r == 4'd15) begin
            chain_nxt = '{md5_pkg::IV0, md5_pkg::IV1, md5_pkg::IV2, md5_pkg::IV3};
            count_nxt = '0;
            state_nxt = md5_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = md5_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= md5_pkg::ST_IDLE;
      ret_r       <= md5_pkg::ST_IDLE;
      chain_r     <= '{md5_pkg::IV0, md5_pkg::IV1, md5_pkg::IV2, md5_pkg::IV3};
      count_r     <= '0;
      round_r     <= '0;
      pad_pos_r   <= '0;
      pad_first_r <= 1'b0;
      len_blk_r   <= 1'b0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      chain_r     <= chain_nxt;
      count_r     <= count_nxt;
      round_r     <= round_nxt;
      pad_pos_r   <= pad_pos_nxt;
      pad_first_r <= pad_first_nxt;
      len_blk_r   <= len_blk_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    out_data_r <= out_data_nxt;
    if (wr_en) begin
      buf_r[wr_pos[5:2]][wr_pos[1:0]] <= wr_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MD5_ASSERT_IMP(a_emit_idx_idle, state_r != md5_pkg::ST_EMIT, emit_idx_r == 4'd0, "emit index left nonzero outside the output phase")
  `MD5_ASSERT_IMP(a_round_wrap, state_r == md5_pkg::ST_FIN, round_r == 6'd0, "round counter did not complete 64 rounds")
  `MD5_ASSERT_NXT(a_reinit, state_r == md5_pkg::ST_EMIT && emit_idx_r == 4'd15 && emit_load, count_r == 64'd0 && chain_r[0] == md5_pkg::IV0, "context not reinitialized after digest")
  `MD5_ASSERT_IMP(a_out_rise, $rose(out_valid_r), $past(state_r) == md5_pkg::ST_EMIT, "digest byte produced outside the output phase")

endmodule

### rtl/md5_message_digest_unit.sv
// A byte that completes a 64-byte block starts its compression. Finish: the command is
// taken, the padding sequencer fills the block byte by byte and one or two blocks are
// compressed, then 16 digest transactions follow, one per cycle while out_ready is high.
// Throughput is set by the single shared round unit: one MD5 round per cycle. Reset is
// synchronous and active low; it loads the initial chaining values and clears the bit
// count. The block buffer is not cleared and needs no clearing pass.
module md5_message_digest_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  md5_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output md5_pkg::out_t out_data
);

  // The front end accepts a transaction whenever its queue has room, so the
  // source keeps streaming while the back end runs rounds. Unused command codes
  // are accepted and dropped there.
  md5_pkg::q_head_t q_head;
  logic             q_pop;

  md5_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // The back end takes one queued command at a time, fills the block buffer,
  // runs the 64 rounds, pads on finish and drives the registered output.
  md5_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### sim/md5_digest_checker.sv
// Checker that predicts MD5 digest bytes from accepted commands and compares outputs.
`timescale 1ns / 100ps
module md5_digest_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  md5_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  md5_pkg::out_t out_data,
  output int            fail_count,
  output int            pending_digest_bytes
);

  logic [31:0] chain [4];
  logic [63:0] bit_count;
  logic [7:0]  block_bytes [64];
  md5_pkg::out_t digest_queue [$];

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  task automatic reload_chain();
    chain[0] = md5_pkg::IV0; chain[1] = md5_pkg::IV1;
    chain[2] = md5_pkg::IV2; chain[3] = md5_pkg::IV3;
    bit_count = '0;
  endtask

  task automatic compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t, sum;
    int g, s;
    for (int i = 0; i < 16; i++)
      w[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      s = ROT[(i / 16) * 4 + i % 4];
      sum = a + f + ROUND_K[i] + w[g];
      t = d; d = c; c = b;
      b = b + ((sum << s) | (sum >> (32 - s)));
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic finish_digest();
    logic [63:0] bits;
    int pos;
    md5_pkg::out_t item;
    bits = bit_count;
    pos = int'(bits[8:3]);
    block_bytes[pos] = md5_pkg::PAD_BYTE;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin block_bytes[pos] = '0; pos++; end
      compress();
      pos = 0;
    end
    while (pos < 56) begin block_bytes[pos] = '0; pos++; end
    for (int i = 0; i < 8; i++) block_bytes[56 + i] = bits[8*i +: 8];
    compress();
    for (int i = 0; i < 16; i++) begin
      item.digest_byte = chain[i / 4][8 * (i % 4) +: 8];
      item.digest_last = (i == 15);
      digest_queue.push_back(item);
    end
    reload_chain();
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    reload_chain();
  end

  assign pending_digest_bytes = digest_queue.size();

  always @(posedge clk) begin
    md5_pkg::out_t want;
    if (!rst_n) begin
      reload_chain();
      digest_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (digest_queue.size() == 0) begin
          report_mismatch("digest byte with nothing expected");
        end else begin
          want = digest_queue.pop_front();
          if (out_data.digest_byte !== want.digest_byte)
            report_mismatch($sformatf("digest_byte got %h want %h",
                                      out_data.digest_byte, want.digest_byte));
          if (out_data.digest_last !== want.digest_last)
            report_mismatch($sformatf("digest_last got %b want %b",
                                      out_data.digest_last, want.digest_last));
        end
      end
      if (in_valid && in_ready) begin
        case (in_data.cmd)
          md5_pkg::CMD_START: reload_chain();
          md5_pkg::CMD_DATA: begin
            block_bytes[bit_count[8:3]] = in_data.data_byte;
            bit_count += 64'd8;
            if (bit_count[8:3] == 6'd0) compress();
          end
          md5_pkg::CMD_FINISH: finish_digest();
          default: ;
        endcase
      end
    end
  end
endmodule

### sim/tb.sv
// Top-level testbench for the MD5 digest unit: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  md5_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  md5_pkg::out_t out_data;
  int   fail_count;
  int   pending_digest_bytes;

  // The sender idles at random except during the calm stretch.
  bit   calm = 1'b0;
  // Set while the receiver deliberately holds off to let digests and messages queue up.
  bit   hold_off = 1'b0;
  int   quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  md5_message_digest_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  md5_digest_checker checker_inst (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_digest_bytes(pending_digest_bytes)
  );

  // Receiver: ready toggles at random on the falling edge, except during the calm
  // stretch (always ready) and the hold-off (never ready).
  always @(negedge clk) begin
    if (hold_off)
      out_ready <= 1'b0;
    else if (calm)
      out_ready <= 1'b1;
    else
      out_ready <= ($urandom_range(99) >= 38);
  end

  // Watchdog: counts cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Presents one transaction from the falling edge and holds it until accepted.
  // Valid stays high afterwards so that transactions can follow back to back; it
  // drops only while the sender idles or when the caller ends a burst.
  task automatic send(input logic [1:0] cmd, input logic [7:0] data);
    if (!calm) begin
      while ($urandom_range(99) < 38) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= '{cmd: cmd, data_byte: data};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_bytes(input int count, input bit random_data, input logic [7:0] fill);
    for (int i = 0; i < count; i++)
      send(md5_pkg::CMD_DATA, random_data ? 8'($urandom) : fill);
  endtask

  // A message length mostly short, sometimes across the padding boundaries.
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(0, 20);
    if (r < 85) return $urandom_range(50, 70);
    return $urandom_range(100, 130);
  endfunction

  initial begin
    int sent;
    int len;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty message straight from reset, then after a start.
    send(md5_pkg::CMD_FINISH, 8'h00);
    send(md5_pkg::CMD_START, 8'hff);
    send(md5_pkg::CMD_FINISH, 8'h00);
    // Unused command is ignored, between bytes of all-ones and all-zeros.
    send(md5_pkg::CMD_DATA, 8'hff);
    send(CMD_UNUSED, 8'h5a);
    send(md5_pkg::CMD_DATA, 8'h00);
    send(CMD_UNUSED, 8'ha5);
    send(md5_pkg::CMD_FINISH, 8'h00);
    // A start in mid-message drops what came before it.
    send(md5_pkg::CMD_DATA, 8'h61);
    send(md5_pkg::CMD_START, 8'h00);
    send(md5_pkg::CMD_DATA, 8'h61);
    send(md5_pkg::CMD_DATA, 8'h62);
    send(md5_pkg::CMD_DATA, 8'h63);
    send(md5_pkg::CMD_FINISH, 8'h00);

    // Calm stretch: no idling on either side; lengths 55, 56 and 64 straddle the
    // pad boundary and the full-block case.
    calm = 1'b1;
    send_bytes(55, 1'b1, 8'h00);
    send(md5_pkg::CMD_FINISH, 8'h00);
    send_bytes(56, 1'b0, 8'hff);
    send(md5_pkg::CMD_FINISH, 8'h00);
    send_bytes(64, 1'b1, 8'h00);
    send(md5_pkg::CMD_FINISH, 8'h00);
    calm = 1'b0;

    // Hold-off: the receiver stops while a digest and more messages queue up.
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        send_bytes(3, 1'b1, 8'h00);
        send(md5_pkg::CMD_FINISH, 8'h00);
        send_bytes(10, 1'b1, 8'h00);
        send(md5_pkg::CMD_FINISH, 8'h00);
        in_valid <= 1'b0;
      end
    join

    // Random part: mostly well-formed messages, with stray commands mixed in.
    sent = 0;
    while (sent < 150) begin
      if ($urandom_range(9) == 0) send(md5_pkg::CMD_START, 8'($urandom));
      len = pick_length();
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(49) == 0) send(CMD_UNUSED, 8'($urandom));
        send(md5_pkg::CMD_DATA, 8'($urandom));
      end
      send(md5_pkg::CMD_FINISH, 8'($urandom));
      sent += len + 1;
    end
    in_valid <= 1'b0;

    while (pending_digest_bytes != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

### md5_message_digest_unit.f
+incdir+rtl
rtl/md5_pkg.sv
rtl/md5_front.sv
rtl/md5_core.sv
rtl/md5_message_digest_unit.sv
sim/md5_digest_checker.sv
sim/tb.sv
